// File: rtl/core/u8s_pkg.sv
// types, constants and the lead byte classifier shared by the utf-8 sanitizer
package u8s_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned HOLD_DEPTH = 4;
    localparam logic [6:0] REPL_RESET = 7'd63;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_replaced;
        logic       out_end_of_string;
    } t_out_item;

    // sequence length announced by a start byte, bad for a byte that cannot start one
    typedef enum logic [2:0] {
        LEN_BAD   = 3'd0,
        LEN_ONE   = 3'd1,
        LEN_TWO   = 3'd2,
        LEN_THREE = 3'd3,
        LEN_FOUR  = 3'd4
    } t_lead_len;

    typedef struct packed {
        logic [7:0] value;
        t_lead_len  lead_len;
        logic       is_cont;
        logic       is_last;
    } t_cls_item;

    function automatic t_lead_len classify(input logic [7:0] b);
        t_lead_len len;
        if (b[7] == 1'b0) begin
            len = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_BAD;
        end
        return len;
    endfunction

endpackage

// File: rtl/core/u8s_front.sv
// front end: accepts input bytes, classifies them and queues them for the engine
module u8s_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8s_pkg::t_in_item     i_in_data,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output u8s_pkg::t_cls_item    o_q_item
);
    import u8s_pkg::*;

    t_cls_item                 r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [QUEUE_FILL_W-1:0]   r_fill;
    logic [QUEUE_FILL_W-1:0]   n_fill;
    logic                      w_push;
    logic                      w_pop;
    t_cls_item                 w_cls;

    assign o_in_stall = (r_fill == QUEUE_FILL_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_fill != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_slot[r_rd_ptr];

    always_comb begin
        w_cls.value    = i_in_data.in_byte;
        w_cls.lead_len = classify(i_in_data.in_byte);
        w_cls.is_cont  = (i_in_data.in_byte[7:6] == 2'b10);
        w_cls.is_last  = i_in_data.in_last;
    end

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!w_push && w_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= n_fill;
        end
    end

endmodule

// File: rtl/core/u8s_back.sv
// back end: holds pending sequences, checks them, emits one byte per cycle unless stalled
module u8s_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [6:0]            i_cfg_data,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  u8s_pkg::t_cls_item    i_q_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8s_pkg::t_out_item    o_out_data
);
    import u8s_pkg::*;

    logic [6:0]  r_repl;
    t_cls_item   r_held [HOLD_DEPTH];
    logic [2:0]  r_count;
    logic [1:0]  r_pass;
    logic        r_last;
    logic        r_out_valid;
    t_out_item   r_out;

    t_cls_item   n_held [HOLD_DEPTH];
    logic [2:0]  n_count;
    logic        n_last;

    t_cls_item   w_shift [HOLD_DEPTH];
    t_cls_item   w_held_after [HOLD_DEPTH];
    logic [2:0]  w_count_after;
    logic [1:0]  w_pass_after;
    t_lead_len   w_len0;
    t_out_item   w_emit;
    logic        w_busy;
    logic        w_out_free;
    logic        w_step;
    logic        w_ok;
    logic        w_idle_after;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_q_pop     = w_pop;

    assign w_len0     = r_held[0].lead_len;
    // work pending: passing a checked sequence, or a start byte that can be resolved now
    assign w_busy     = (r_pass != 2'd0) ||
                        ((r_count != 3'd0) && !((r_count < w_len0) && !r_last));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = w_busy && w_out_free;
    assign w_ok       = r_held[1].is_cont &&
                        ((w_len0 == LEN_TWO) || r_held[2].is_cont) &&
                        ((w_len0 != LEN_FOUR) || r_held[3].is_cont);

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            w_shift[i] = r_held[i+1];
        end
        w_shift[HOLD_DEPTH-1] = r_held[HOLD_DEPTH-1];
    end

    // one iteration of the rescan loop
    always_comb begin
        w_held_after  = r_held;
        w_count_after = r_count;
        w_pass_after  = r_pass;
        w_emit.out_byte          = r_held[0].value;
        w_emit.out_replaced      = 1'b0;
        w_emit.out_end_of_string = 1'b0;
        if (w_step) begin
            if (r_pass != 2'd0) begin
                w_held_after  = w_shift;
                w_count_after = r_count - 3'd1;
                w_pass_after  = r_pass - 2'd1;
            end else begin
                case (w_len0)
                    LEN_ONE: begin
                        w_held_after  = w_shift;
                        w_count_after = r_count - 3'd1;
                    end
                    LEN_TWO, LEN_THREE, LEN_FOUR: begin
                        if (r_count < w_len0) begin
                            // string ended inside a sequence
                            w_emit.out_byte     = {1'b0, r_repl};
                            w_emit.out_replaced = 1'b1;
                            w_count_after       = 3'd0;
                        end else if (w_ok) begin
                            w_held_after  = w_shift;
                            w_count_after = r_count - 3'd1;
                            w_pass_after  = 2'(w_len0 - 3'd1);
                        end else begin
                            w_emit.out_byte     = {1'b0, r_repl};
                            w_emit.out_replaced = 1'b1;
                            w_held_after        = w_shift;
                            w_count_after       = r_count - 3'd1;
                        end
                    end
                    default: begin
                        w_emit.out_byte     = {1'b0, r_repl};
                        w_emit.out_replaced = 1'b1;
                        w_held_after        = w_shift;
                        w_count_after       = r_count - 3'd1;
                    end
                endcase
            end
            w_emit.out_end_of_string = r_last && (w_count_after == 3'd0);
        end
    end

    assign w_idle_after = (w_pass_after == 2'd0) &&
                          ((w_count_after == 3'd0) ||
                           ((w_count_after < w_held_after[0].lead_len) && !r_last));
    assign w_pop        = w_idle_after && i_q_valid;

    always_comb begin
        n_held  = w_held_after;
        n_count = w_count_after;
        n_last  = r_last;
        if (w_pop) begin
            n_held[w_count_after[1:0]] = i_q_item;
            n_count = w_count_after + 3'd1;
            n_last  = i_q_item.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (w_step) begin
            r_out <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl      <= REPL_RESET;
            r_count     <= 3'd0;
            r_pass      <= 2'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_repl <= i_cfg_data;
            end
            r_count <= n_count;
            r_pass  <= w_pass_after;
            r_last  <= n_last;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(HOLD_DEPTH))
        else $error("held count beyond buffer depth");

    a_pass_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pass != 2'd0) |-> (r_count >= {1'b0, r_pass}))
        else $error("pass count exceeds held bytes");

    a_pass_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pass != 2'd0) |-> r_held[0].is_cont)
        else $error("passing a byte that is not a continuation");

    a_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_out) && r_out_valid))
        else $error("output register overwritten while stalled");

endmodule

// File: rtl/core/utf8_byte_sanitizer.sv
// top level of the streaming utf-8 sanitizer with byte replacement
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in       | sink      | i_in_valid/o_in_stall   | t_in_item  (byte, last flag)
//  out      | source    | o_out_valid/i_out_stall | t_out_item (byte, replaced, end)
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | 7-bit replacement byte
//
//  one result per cycle leaves through the output register of the back end unless stalled
//  an ascii stream flows at one byte per cycle unless stalled; an n-byte sequence is
//  collected one byte per pop, then emitted byte by byte through the single emit port
//  a bad start or bad continuation is replaced and the held bytes behind it rescanned
//  synchronous active-low reset; replacement byte resets to '?'
//  the two-entry queue keeps taking input while the output side is stalled, until full
module utf8_byte_sanitizer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [6:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8s_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8s_pkg::t_out_item    o_out_data
);
    import u8s_pkg::*;

    // classified bytes between front and back
    logic       w_q_valid;
    logic       w_q_pop;
    t_cls_item  w_q_item;

    // front: byte classification and decoupling queue
    u8s_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_item   (w_q_item)
    );

    // back: held sequence buffer, validation, rescan and output register
    u8s_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_item    (w_q_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: verif/utf8_sanitizer_check.sv
// checker for the utf-8 sanitizer: predicts every output transfer and compares it
module utf8_sanitizer_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  u8s_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  u8s_pkg::t_out_item i_out_data,
    output int                 o_mismatches,
    output int                 o_due
);
    import u8s_pkg::*;

    logic [7:0] held [HOLD_DEPTH];
    int         held_cnt;
    logic [6:0] repl_byte;
    t_out_item  clean_due [$];

    function automatic t_lead_len start_len(input logic [7:0] b);
        if (b inside {[8'h00:8'h7F]}) return LEN_ONE;
        if (b inside {[8'hC0:8'hDF]}) return LEN_TWO;
        if (b inside {[8'hE0:8'hEF]}) return LEN_THREE;
        if (b inside {[8'hF0:8'hF7]}) return LEN_FOUR;
        return LEN_BAD;
    endfunction

    task automatic drop_held(input int k);
        if (k >= held_cnt) begin
            held_cnt = 0;
        end else begin
            for (int i = 0; i < held_cnt - k; i++) held[i] = held[i + k];
            held_cnt = held_cnt - k;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    // expected output transfers caused by one accepted byte
    task automatic sanitize_byte(input logic [7:0] b, input logic last);
        t_out_item batch [4];
        int        n;
        int        need;
        t_lead_len len;
        logic      ok;
        n = 0;
        held[held_cnt] = b;
        held_cnt++;
        while (held_cnt > 0) begin
            len  = start_len(held[0]);
            need = int'(len);
            if (len == LEN_ONE) begin
                if (n < 4) begin
                    batch[n] = '{out_byte: held[0], out_replaced: 1'b0,
                                 out_end_of_string: 1'b0};
                    n++;
                end
                drop_held(1);
            end else if (len == LEN_BAD) begin
                if (n < 4) begin
                    batch[n] = '{out_byte: {1'b0, repl_byte}, out_replaced: 1'b1,
                                 out_end_of_string: 1'b0};
                    n++;
                end
                drop_held(1);
            end else if (held_cnt < need) begin
                // sequence incomplete; if the string ends here: one replacement, rest dropped
                if (last) begin
                    if (n < 4) begin
                        batch[n] = '{out_byte: {1'b0, repl_byte}, out_replaced: 1'b1,
                                     out_end_of_string: 1'b0};
                        n++;
                    end
                    held_cnt = 0;
                end
                break;
            end else begin
                ok = 1'b1;
                for (int j = 1; j < need; j++)
                    if (held[j][7:6] != 2'b10) ok = 1'b0;
                if (ok) begin
                    for (int j = 0; j < need; j++) begin
                        if (n < 4) begin
                            batch[n] = '{out_byte: held[j], out_replaced: 1'b0,
                                         out_end_of_string: 1'b0};
                            n++;
                        end
                    end
                    drop_held(need);
                end else begin
                    // bad continuation: replace the lead, rescan what follows it
                    if (n < 4) begin
                        batch[n] = '{out_byte: {1'b0, repl_byte}, out_replaced: 1'b1,
                                     out_end_of_string: 1'b0};
                        n++;
                    end
                    drop_held(1);
                end
            end
        end
        if (last && n > 0) batch[n - 1].out_end_of_string = 1'b1;
        for (int i = 0; i < n; i++) clean_due = {clean_due, batch[i]};
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clean_due.delete();
            for (int i = 0; i < HOLD_DEPTH; i++) held[i] = 8'h00;
            held_cnt     = 0;
            repl_byte    = REPL_RESET;
            o_due        = 0;
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) repl_byte = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                sanitize_byte(i_in_data.in_byte, i_in_data.in_last);
            if (i_out_valid && !i_out_stall) begin
                if (clean_due.size() == 0) begin
                    report_mismatch("output transfer with nothing expected",
                                    i_out_data.out_byte, 8'h00);
                end else begin
                    want = clean_due.pop_front();
                    if (i_out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", i_out_data.out_byte, want.out_byte);
                    if (i_out_data.out_replaced !== want.out_replaced)
                        report_mismatch("out_replaced", 8'(i_out_data.out_replaced),
                                        8'(want.out_replaced));
                    if (i_out_data.out_end_of_string !== want.out_end_of_string)
                        report_mismatch("out_end_of_string",
                                        8'(i_out_data.out_end_of_string),
                                        8'(want.out_end_of_string));
                end
            end
            o_due = clean_due.size();
        end
    end

endmodule

// File: verif/tb_utf8_byte_sanitizer.sv
// testbench top for the utf-8 sanitizer: stimulus, idling and the verdict
module tb_utf8_byte_sanitizer;
    import u8s_pkg::*;

    localparam int LIMIT_CYCLES = 200000;   // far above the slowest correct run
    localparam int SETTLE       = 20;       // covers a 4-byte sequence plus the output register
    localparam int PHASE_ITEMS  = 94;       // five random phases, about 470 bytes in all

    typedef logic [7:0] t_bytes [$];

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data  = 7'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;

    logic       quiet     = 1'b0;   // when set neither side idles
    int         bytes_sent = 0;
    int         cycles     = 0;
    int         mismatches;
    int         due;

    utf8_byte_sanitizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // watches all three channels, predicts and compares
    utf8_sanitizer_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_due        (due)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, counted in rising edges
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("utf8_byte_sanitizer verification failed");
            $finish;
        end
    end

    // receiver backpressure, a stall drawn with a 29 percent chance unless quiet
    always @(negedge clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 29);
    end

    // one byte transfer on the input channel, with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        // payload holds until the transfer happens
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // a whole string, the final byte flagged as last
    task automatic push_string(input t_bytes s);
        foreach (s[i]) push_byte(s[i], i == s.size() - 1);
    endtask

    // lead byte of a 2, 3 or 4 byte sequence with random payload bits
    function automatic logic [7:0] start_byte(input int len);
        case (len)
            2: return {3'b110, 5'($urandom_range(0, 31))};
            3: return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // mostly well-formed characters, some truncated or broken ones and stray bytes
    function automatic t_bytes random_string();
        t_bytes s;
        int     kind;
        int     len;
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                s = {s, 8'($urandom_range(0, 127))};
            end else if (kind < 82) begin
                len = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
                s = {s, start_byte(len)};
                repeat (len - 1) s = {s, cont_byte()};
            end else if (kind < 88) begin
                // sequence cut short, whatever comes next decides its fate
                len = $urandom_range(2, 4);
                s = {s, start_byte(len)};
                repeat ($urandom_range(0, len - 2)) s = {s, cont_byte()};
            end else if (kind < 94) begin
                // sequence broken by a byte that is not a continuation
                len = $urandom_range(2, 4);
                s = {s, start_byte(len)};
                repeat ($urandom_range(0, len - 2)) s = {s, cont_byte()};
                if ($urandom_range(0, 1))
                    s = {s, 8'($urandom_range(0, 127))};
                else
                    s = {s, {2'b11, 6'($urandom_range(0, 63))}};
            end else begin
                // byte that can never start a sequence
                if ($urandom_range(0, 1))
                    s = {s, cont_byte()};
                else
                    s = {s, {5'b11111, 3'($urandom_range(0, 7))}};
            end
        end
        return s;
    endfunction

    task automatic run_random(input int count);
        int stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop) push_string(random_string());
    endtask

    // sender holds off until every expected output transfer has come, then settles
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // replacement byte write, only issued while the block is idle
    task automatic write_repl(input logic [6:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_bytes word;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, replacement byte at its reset value
        word = {8'h00, 8'h7F};                        // ascii extremes, last on 0x7f
        push_string(word);
        word = {8'h80, 8'hFF,                         // invalid start bytes
                8'hC2, 8'hA9,                         // two byte character
                8'hE2, 8'h82, 8'hAC,                  // three byte character
                8'hF0, 8'h9F, 8'h98, 8'h80};          // four byte character ending the string
        push_string(word);
        word = {8'hE2, 8'h41, 8'h42};                 // bad continuation, held bytes rescanned
        push_string(word);
        word = {8'hF0, 8'h9F};                        // string ends inside a sequence
        push_string(word);
        word = {8'hC3};                               // lone lead as the whole string
        push_string(word);
        word = {8'hC3, 8'hC3, 8'hA9};                 // lead broken by another lead
        push_string(word);
        wait_drained();

        // random phases, each under its own replacement byte
        write_repl(7'd0);
        run_random(PHASE_ITEMS);
        wait_drained();

        write_repl(7'd127);
        run_random(PHASE_ITEMS / 2);
        wait_drained();                               // mid-phase hold-off, no write
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_drained();

        // long stretch with neither side idling
        write_repl(7'($urandom_range(1, 126)));
        quiet <= 1'b1;
        run_random(PHASE_ITEMS);
        wait_drained();
        quiet <= 1'b0;

        write_repl(7'($urandom_range(1, 126)));
        run_random(PHASE_ITEMS);
        wait_drained();

        write_repl(REPL_RESET);
        run_random(PHASE_ITEMS);
        wait_drained();

        if (mismatches == 0) begin
            $display("utf8_byte_sanitizer verification clean");
        end else begin
            $display("utf8_byte_sanitizer verification failed");
        end
        $finish;
    end

endmodule
